/* rtl/assert_macros.svh */
// Assertion helpers used by huffman_code_bit_packer.
// Both macros check a property on the rising clock edge outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hcbp_pkg.sv */
package hcbp_pkg;

  // Field widths and table size.
  localparam int NUM_SYM          = 256;
  localparam int SYM_W            = 8;
  localparam int CODE_W           = 32;
  localparam int LEN_IN_W         = 6;
  localparam int BYTE_W           = 8;
  localparam int CNT_W            = $clog2(BYTE_W);
  localparam int MAX_CODE_LEN_DEF = 32;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_ERROR,
    ST_SHIFT,
    ST_FLUSH
  } state_t;

  // Input request payload.
  typedef struct packed {
    logic [1:0]          func;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_IN_W-1:0] code_len;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              kind;
    logic              last;
  } out_t;

  // Sequencer to packer controls.
  typedef struct packed {
    logic push;
    logic din;
    logic last;
    logic direct;
    logic direct_kind;
  } pk_ctl_t;

  // Packer to sequencer status.
  typedef struct packed {
    logic bit_ready;
    logic out_free;
    logic pend_empty;
  } pk_sts_t;

endpackage

/* rtl/hcbp_ram.sv */
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/hcbp_packer.sv */
module hcbp_packer (
  input  logic             clk,
  input  logic             rst_n,
  input  hcbp_pkg::pk_ctl_t ctl,
  output hcbp_pkg::pk_sts_t sts,
  output logic             out_valid,
  input  logic             out_ready,
  output hcbp_pkg::out_t   out_res
);

  localparam int BYTE_W = hcbp_pkg::BYTE_W;
  localparam int CNT_W  = hcbp_pkg::CNT_W;

  logic [BYTE_W-2:0] pend_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  hcbp_pkg::out_t    out_res_r;
  logic              out_free;
  logic              byte_full;

  // The output register can take a result when empty or when drained now.
  assign out_free  = !out_valid_r || out_ready;
  assign byte_full = (cnt_r == CNT_W'(BYTE_W - 1));

  assign sts.bit_ready  = !byte_full || out_free;
  assign sts.out_free   = out_free;
  assign sts.pend_empty = (cnt_r == '0);

  // Pending-bit count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (ctl.push && sts.bit_ready) begin
      if (byte_full) begin
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end else if (ctl.direct && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Bit shift register and result payload.
  always_ff @(posedge clk) begin
    if (ctl.push && sts.bit_ready) begin
      pend_r <= {pend_r[BYTE_W-3:0], ctl.din};
      if (byte_full) begin
        out_res_r.out_byte <= {pend_r, ctl.din};
        out_res_r.kind     <= 1'b0;
        out_res_r.last     <= ctl.last;
      end
    end else if (ctl.direct && out_free) begin
      out_res_r.out_byte <= '0;
      out_res_r.kind     <= ctl.direct_kind;
      out_res_r.last     <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* rtl/huffman_code_bit_packer.sv */
// Huffman code bit packer.
// Requests arrive on in_valid/in_ready with an in_req payload; results leave
// on out_valid/out_ready with an out_res payload. A load request writes one
// code table entry and gives no result. An encode request reads the table,
// then shifts the code into the byte register one bit per cycle while the
// output is not stalled, most significant first; every full byte is a result,
// and the last one of the request has last set. A symbol without a code gives
// one error result. A flush request pads the pending bits with zeros, one per
// cycle while the output can take a byte, and then gives the zero trailer byte
// with last set.
// The bit-serial shift path sets the rate: one code bit per cycle when the output
// does not stall, one request at a time; in_ready is high only between requests.
// Results sit in a single output register; while the receiver stalls with a
// result held there, shifting pauses at the bit that completes the next byte.
// Reset clears the pending-bit count and the per-symbol valid flags, so every
// symbol starts without a code; no clearing pass is needed.
`include "assert_macros.svh"

module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hcbp_pkg::in_t  in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output hcbp_pkg::out_t out_res
);

  localparam int CODE_W  = hcbp_pkg::CODE_W;
  localparam int NUM_SYM = hcbp_pkg::NUM_SYM;
  localparam int LIN_W   = hcbp_pkg::LEN_IN_W;
  localparam int BYTE_W  = hcbp_pkg::BYTE_W;
  localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int ENT_W   = CODE_W + LEN_W;
  localparam int CIDX_W  = $clog2(CODE_W);
  localparam int SEL_W   = (LEN_W > CIDX_W) ? LEN_W : CIDX_W;

  hcbp_pkg::state_t  state_r, state_nxt;
  logic [NUM_SYM-1:0] vld_r;
  logic              hit_r;
  logic [CODE_W-1:0] code_r;
  logic [LEN_W-1:0]  bitcnt_r, bitcnt_nxt;
  logic              in_acc;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  rd_len;
  logic [SEL_W-1:0]  pos;
  logic              code_bit;
  hcbp_pkg::pk_ctl_t pk_ctl;
  hcbp_pkg::pk_sts_t pk_sts;

  assign in_ready = (state_r == hcbp_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Lengths above the maximum are stored as the maximum.
  always_comb begin
    if (in_req.code_len > LIN_W'(MAX_CODE_LEN)) begin
      len_clamp = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_clamp = LEN_W'(in_req.code_len);
    end
  end

  assign ram_we    = in_acc && (in_req.func == hcbp_pkg::FUNC_LOAD);
  assign ram_wdata = {len_clamp, in_req.code_bits};

  // Code table: code and length per symbol; the read follows the request.
  hcbp_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_SYM)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(in_req.symbol),
    .wdata(ram_wdata),
    .raddr(in_req.symbol),
    .rdata(ram_rdata)
  );

  // Per-symbol valid flags; a symbol never loaded has no code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ram_we) begin
      vld_r[in_req.symbol] <= 1'b1;
    end
  end

  // Valid flag read alongside the table read.
  always_ff @(posedge clk) begin
    hit_r <= vld_r[in_req.symbol];
  end

  assign rd_len = hit_r ? ram_rdata[ENT_W-1:CODE_W] : '0;

  // Code word held during shifting.
  always_ff @(posedge clk) begin
    if (state_r == hcbp_pkg::ST_LOOKUP) begin
      code_r <= ram_rdata[CODE_W-1:0];
    end
  end

  // Select the next code bit, most significant first.
  assign pos      = SEL_W'(bitcnt_r) - SEL_W'(1);
  assign code_bit = (int'(pos) < CODE_W) ? code_r[pos[CIDX_W-1:0]] : 1'b0;

  // State and remaining-bit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= hcbp_pkg::ST_IDLE;
      bitcnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      bitcnt_r <= bitcnt_nxt;
    end
  end

  // Sequencer: next state and packer controls.
  always_comb begin
    state_nxt          = state_r;
    bitcnt_nxt         = bitcnt_r;
    pk_ctl.push        = 1'b0;
    pk_ctl.din         = 1'b0;
    pk_ctl.last        = 1'b0;
    pk_ctl.direct      = 1'b0;
    pk_ctl.direct_kind = 1'b0;
    unique case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_req.func)
            hcbp_pkg::FUNC_ENCODE: state_nxt = hcbp_pkg::ST_LOOKUP;
            hcbp_pkg::FUNC_FLUSH:  state_nxt = hcbp_pkg::ST_FLUSH;
            default:               state_nxt = hcbp_pkg::ST_IDLE;
          endcase
        end
      end
      hcbp_pkg::ST_LOOKUP: begin
        bitcnt_nxt = rd_len;
        if (rd_len == '0) begin
          state_nxt = hcbp_pkg::ST_ERROR;
        end else begin
          state_nxt = hcbp_pkg::ST_SHIFT;
        end
      end
      hcbp_pkg::ST_ERROR: begin
        pk_ctl.direct      = 1'b1;
        pk_ctl.direct_kind = 1'b1;
        if (pk_sts.out_free) begin
          state_nxt = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_SHIFT: begin
        pk_ctl.push = 1'b1;
        pk_ctl.din  = code_bit;
        // A byte completed here is the last one if fewer than a byte remain.
        pk_ctl.last = (int'(bitcnt_r) <= BYTE_W);
        if (pk_sts.bit_ready) begin
          bitcnt_nxt = bitcnt_r - LEN_W'(1);
          if (bitcnt_r == LEN_W'(1)) begin
            state_nxt = hcbp_pkg::ST_IDLE;
          end
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (!pk_sts.pend_empty) begin
          // Pad the partial byte with zeros.
          pk_ctl.push = 1'b1;
        end else begin
          // Trailer byte closes the stream.
          pk_ctl.direct = 1'b1;
          if (pk_sts.out_free) begin
            state_nxt = hcbp_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = hcbp_pkg::ST_IDLE;
    endcase
  end

  hcbp_packer u_packer (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pk_ctl),
    .sts      (pk_sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  // Shifting never runs with no code bits left.
  `ASSERT_IMPL(a_shift_cnt, clk, rst_n, state_r == hcbp_pkg::ST_SHIFT, bitcnt_r != '0)
  // An error result carries a zero byte and closes its request.
  `ASSERT_IMPL(a_err_res, clk, rst_n, out_valid && out_res.kind,
               out_res.last && (out_res.out_byte == '0))
  // A finished flush leaves no pending bits.
  `ASSERT_NEXT(a_flush_empty, clk, rst_n,
               (state_r == hcbp_pkg::ST_FLUSH) && (state_nxt == hcbp_pkg::ST_IDLE),
               pk_sts.pend_empty)

endmodule

/* tb/huffman_code_bit_packer_tb.sv */
module huffman_code_bit_packer_tb;

  localparam int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF;
  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_COUNT = 4;
  localparam int PHASE_ITEMS = 102;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Tracks the code table and the partial byte, and holds the bytes still owed.
  class packed_byte_scoreboard;
    logic [31:0]    code_tab [256];
    logic [5:0]     len_tab [256];
    logic [6:0]     pend_bits;
    int             pend_cnt;
    hcbp_pkg::out_t expected_bytes [$];
    int             errors;

    function new();
      foreach (len_tab[i]) begin
        len_tab[i] = '0;
        code_tab[i] = '0;
      end
      pend_bits = '0;
      pend_cnt = 0;
      errors = 0;
    endfunction

    // Works out every byte that one accepted request must produce.
    function void add_request(hcbp_pkg::in_t r);
      hcbp_pkg::out_t batch [$];
      hcbp_pkg::out_t item;
      logic [63:0]    acc;
      logic [63:0]    part;
      int             len;
      int             total;
      unique case (r.func)
        hcbp_pkg::FUNC_LOAD: begin
          code_tab[r.symbol] = r.code_bits;
          len_tab[r.symbol] = (r.code_len > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : r.code_len;
        end
        hcbp_pkg::FUNC_ENCODE: begin
          len = len_tab[r.symbol];
          if (len == 0) begin
            // No code for this symbol: one error result, accumulator untouched.
            item.out_byte = 8'h00;
            item.kind = 1'b1;
            item.last = 1'b1;
            batch = {batch, item};
          end else begin
            acc = ({57'd0, pend_bits} << len)
                | ({32'd0, code_tab[r.symbol]} & ((64'd1 << len) - 64'd1));
            total = pend_cnt + len;
            while (total >= 8) begin
              part = acc >> (total - 8);
              item.out_byte = part[7:0];
              item.kind = 1'b0;
              item.last = 1'b0;
              batch = {batch, item};
              total -= 8;
            end
            pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
            pend_cnt = total;
          end
        end
        hcbp_pkg::FUNC_FLUSH: begin
          // The partial byte goes out left-aligned, then the zero trailer.
          if (pend_cnt != 0) begin
            part = {57'd0, pend_bits} << (8 - pend_cnt);
            item.out_byte = part[7:0];
            item.kind = 1'b0;
            item.last = 1'b0;
            batch = {batch, item};
          end
          item.out_byte = 8'h00;
          item.kind = 1'b0;
          item.last = 1'b0;
          batch = {batch, item};
          pend_bits = '0;
          pend_cnt = 0;
        end
        default: ;
      endcase
      if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
      expected_bytes = {expected_bytes, batch};
    endfunction

    // Compares one accepted result with the oldest byte still owed.
    function void check_result(hcbp_pkg::out_t got);
      hcbp_pkg::out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: byte %02h kind %0d last %0d",
                 $time, got.out_byte, got.kind, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: result mismatch: expected byte %02h kind %0d last %0d, %s",
                 $time, want.out_byte, want.kind, want.last, "got:");
        $display("%0t:   actual byte %02h kind %0d last %0d",
                 $time, got.out_byte, got.kind, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hcbp_pkg::in_t  in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hcbp_pkg::out_t out_res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_request = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [7:0] coded_syms [$];
  packed_byte_scoreboard board;

  huffman_code_bit_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res(out_res)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic hcbp_pkg::in_t make_req(logic [1:0] func, logic [7:0] sym,
                                             logic [31:0] bits, logic [5:0] len);
    hcbp_pkg::in_t r;
    r.func = func;
    r.symbol = sym;
    r.code_bits = bits;
    r.code_len = len;
    return r;
  endfunction

  // Offers one request, with random idle cycles first, and waits for it to be taken.
  task automatic send_req(hcbp_pkg::in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    board.add_request(r);
  endtask

  // Result side: check each accepted result, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_res);
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      // Long hold-off so the block backs up and stalls its input.
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: give up when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int          pick;
    int          lp;
    logic [7:0]  sym;
    logic [5:0]  len;
    int          idle_by_phase [PHASE_COUNT];
    int          stall_by_phase [PHASE_COUNT];
    idle_by_phase = '{0, 51, 0, 14};
    stall_by_phase = '{0, 0, 51, 14};
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: errors, empty flush, ignored function, extreme codes.
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0));
    send_req(make_req(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd1));
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd63));
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'hAA, 32'h0000_0005, 6'd3));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'hFF, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h55, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'hAA, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'h12, 32'h0000_00C3, 6'd8));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h12, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'hAA, 32'h0, 6'd0));
    // Removing a code, then encoding it while bits are pending.
    send_req(make_req(hcbp_pkg::FUNC_LOAD, 8'h12, 32'hFFFF_FFFF, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h12, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'hAA, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_ENCODE, 8'h00, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_FLUSH, 8'h00, 32'h0, 6'd0));
    send_req(make_req(FUNC_UNUSED, 8'h00, 32'h0, 6'd0));
    send_req(make_req(hcbp_pkg::FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    coded_syms = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h12};

    // Random requests in phases with different idle and stall rates.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      send_idle_pct = idle_by_phase[phase];
      recv_stall_pct = stall_by_phase[phase];
      if (phase == 0) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 14) begin
          // Table load: mostly short codes, some long, some clamped, a few removed.
          sym = 8'($urandom_range(255));
          lp = $urandom_range(99);
          if (lp < 5) len = 6'd0;
          else if (lp < 10) len = 6'($urandom_range(63, 33));
          else if (lp < 20) len = 6'($urandom_range(32, 13));
          else len = 6'($urandom_range(12, 1));
          if (len != 0) coded_syms = {coded_syms, sym};
          send_req(make_req(hcbp_pkg::FUNC_LOAD, sym, $urandom, len));
        end else if (pick < 86) begin
          // Encode: mostly symbols that were given a code.
          if ($urandom_range(99) < 90) sym = coded_syms[$urandom_range(coded_syms.size() - 1)];
          else sym = 8'($urandom_range(255));
          send_req(make_req(hcbp_pkg::FUNC_ENCODE, sym, $urandom, 6'($urandom_range(63))));
        end else if (pick < 97) begin
          send_req(make_req(hcbp_pkg::FUNC_FLUSH, 8'($urandom_range(255)), $urandom,
                            6'($urandom_range(63))));
        end else begin
          send_req(make_req(FUNC_UNUSED, 8'($urandom_range(255)), $urandom,
                            6'($urandom_range(63))));
        end
      end
    end
    in_valid <= 1'b0;

    // Drain the owed bytes, then watch a while for anything extra.
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_bytes.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, board.expected_bytes.size());
    if (board.errors == 0 && board.expected_bytes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
